[sv/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 package
// Constants and helpers shared by the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
  localparam int unsigned LengthBitsDefault = 64;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction
endpackage
`default_nettype wire

[sv/sha1_message_digest.sv]
// SHA-1 digest, one message byte per transfer in, 20 digest bytes out.
// A byte is taken per cycle while the input is ready; the 64th byte of a block stalls the input
// while the block words load, 80 rounds run at one per cycle and the chain is added.
// The last transfer pads with up to 72 bytes, one per cycle, and one or two blocks.
// Digest bytes leave one per cycle while m_tready is high once compression is done, then re-init.
// Synchronous reset restores the chaining words and clears the bit count.
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Block buffer held in a word-wide memory, schedule window in a shift register.
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_message_digest #(
  parameter int unsigned LENGTH_BITS = sha1_pkg::LengthBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // data_byte
  input  wire logic        s_tuser,  // has_byte
  input  wire logic        s_tlast,  // last_item
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // digest_byte
  output logic             m_tlast   // digest_last
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PAD  = 7'b0000010, S_LOAD = 7'b0000100,
    S_RND  = 7'b0001000, S_ADD  = 7'b0010000, S_OUT  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [LENGTH_BITS-1:0] bit_count, len;
  logic [31:0] buf_mem [16];
  logic [31:0] word_rd;
  logic [6:0]  rnd;
  logic [4:0]  ocnt;
  logic        pad_mode, ld_phase, fin_blk;
  logic [7:0]  pad_byte;
  logic [31:0] w0, w_new, f, k, t;
  logic [5:0]  pos;
  logic        push;
  logic [7:0]  push_val;
  logic [31:0] win_a, win_b, win_c, win_d;

  assign pos = bit_count[8:3];
  assign s_tready = (state == S_IDLE);

  // Byte for padding at the current position
  always_comb begin
    logic [63:0] l64;
    l64 = 64'(len);
    pad_byte = 8'h00;
    if (bit_count == len) pad_byte = sha1_pkg::PadByte;
    else if (fin_blk && pos >= sha1_pkg::LenPos) pad_byte = l64[8*(7-int'(pos[2:0])) +: 8];
  end

  always_comb begin
    push = 1'b0;
    push_val = s_tdata;
    if (state == S_IDLE && s_tvalid && s_tuser) push = 1'b1;
    if (state == S_PAD) begin
      push = 1'b1;
      push_val = pad_byte;
    end
  end

  // Schedule window: registers read at fixed taps, shifted each round and as block words load
  logic [31:0] win [16];
  assign win_a = win[13]; assign win_b = win[8]; assign win_c = win[2]; assign win_d = win[0];
  assign w_new = sha1_pkg::rotl(win_a ^ win_b ^ win_c ^ win_d, 1);
  assign w0 = (rnd < 7'd16) ? win[0] : w_new;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = sha1_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = sha1_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d; k = sha1_pkg::K3;
    end
  end
  assign t = sha1_pkg::rotl(a, 5) + f + e + w0 + k;

  // Block buffer memory: byte-lane write, registered read of one word
  always_ff @(posedge clk) begin
    if (push) buf_mem[pos[5:2]][8*(3-int'(pos[1:0])) +: 8] <= push_val;
    word_rd <= buf_mem[rnd[3:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      h[0] <= sha1_pkg::H0; h[1] <= sha1_pkg::H1; h[2] <= sha1_pkg::H2;
      h[3] <= sha1_pkg::H3; h[4] <= sha1_pkg::H4;
      bit_count <= '0;
      pad_mode <= 1'b0;
      fin_blk <= 1'b0;
      rnd <= '0;
      ocnt <= '0;
      ld_phase <= 1'b0;
    end else begin
      if (push) bit_count <= bit_count + LENGTH_BITS'(8);
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          if (s_tuser && pos == 6'd63) begin
            state <= S_LOAD; rnd <= '0; ld_phase <= 1'b0; pad_mode <= s_tlast;
          end else if (s_tlast) begin
            state <= S_PAD; pad_mode <= 1'b1;
          end
          if (s_tlast) begin
            len <= s_tuser ? bit_count + LENGTH_BITS'(8) : bit_count;
            fin_blk <= 1'b0;
          end
        end
        S_PAD: begin
          // note whether the length fits behind the pad byte in this block
          if (bit_count == len) fin_blk <= (pos < sha1_pkg::LenPos);
          if (pos == 6'd63) begin
            state <= S_LOAD; rnd <= '0; ld_phase <= 1'b0;
          end
        end
        S_LOAD: begin
          // registered read: word for rnd-1 arrives now
          if (ld_phase) win[15] <= word_rd;
          if (ld_phase) for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          ld_phase <= 1'b1;
          if (ld_phase && rnd == 7'd16) begin
            state <= S_RND; rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end else rnd <= rnd + 7'd1;
        end
        S_RND: begin
          e <= d; d <= c; c <= sha1_pkg::rotl(b, 30); b <= a; a <= t;
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w0;
          if (rnd == 7'd79) state <= S_ADD;
          rnd <= rnd + 7'd1;
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          ocnt <= '0;
          if (!pad_mode) state <= S_IDLE;
          else if (fin_blk) state <= S_OUT;
          else begin
            // the next block carries the length, and the pad byte too if it is not yet placed
            state <= S_PAD;
            if (bit_count != len) fin_blk <= 1'b1;
          end
        end
        S_OUT: if (m_tready) begin
          if (ocnt == 5'd19) begin
            ocnt <= '0;
            state <= S_FIN;
          end else ocnt <= ocnt + 5'd1;
        end
        S_FIN: begin
          h[0] <= sha1_pkg::H0; h[1] <= sha1_pkg::H1; h[2] <= sha1_pkg::H2;
          h[3] <= sha1_pkg::H3; h[4] <= sha1_pkg::H4;
          bit_count <= '0; pad_mode <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [31:0] ow;
  assign ow = h[ocnt[4:2]];
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = ow[8*(3-int'(ocnt[1:0])) +: 8];
  assign m_tlast = (ocnt == 5'd19);

  property p_out_only_in_out;
    @(posedge clk) disable iff (rst) m_tvalid |-> !s_tready;
  endproperty
  a_out: assert property (p_out_only_in_out) else $error("output during input");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid) else $error("extra digest byte");
  a_ocnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (ocnt < 5'd20)) else $error("digest index out of range");
endmodule
`default_nettype wire
